[rtl/srfc_pkg.sv]
// srfc_pkg: constants, types and the sequencer state type for the secant root finder
// no dependencies
`timescale 1ns / 1ps
package srfc_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int TOL_W = 31;
	localparam int ITER_W = 8;
	localparam int STAT_W = 2;
	localparam int PROD_W = 2 * WORD_WIDTH;
	localparam int CNT_W = $clog2(PROD_W + 1);

	localparam logic [0:0] REG_TOLERANCE = 1'b0;
	localparam logic [0:0] REG_MAX_ITER = 1'b1;
	localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
	localparam logic [STAT_W-1:0] ST_LIMIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd2;

	localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic signed [WORD_WIDTH-1:0] FIVE =
		WORD_WIDTH'(5) <<< FRAC_BITS;

	typedef logic signed [WORD_WIDTH-1:0] word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_F0A, S_F0B, S_F0C, S_FPA, S_FPB, S_FPC,
		S_DEN, S_NUM, S_DIV, S_STEP, S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_WIDTH:0] s;
		s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
		if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
			return s[WORD_WIDTH] ? WMIN : WMAX;
		return s[WORD_WIDTH-1:0];
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_WIDTH:0] s;
		s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
		if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
			return s[WORD_WIDTH] ? WMIN : WMAX;
		return s[WORD_WIDTH-1:0];
	endfunction

	function automatic logic [WORD_WIDTH-1:0] mag(input word_t v);
		return v[WORD_WIDTH-1] ? WORD_WIDTH'(-v) : v;
	endfunction

	// saturate sign plus wide magnitude to the word range
	function automatic word_t sat_mag(input logic neg, input logic [PROD_W-1:0] m);
		logic [PROD_W-1:0] lim;
		logic [PROD_W-1:0] v;
		lim = neg ? PROD_W'({1'b1, {(WORD_WIDTH-1){1'b0}}})
			: PROD_W'({1'b0, {(WORD_WIDTH-1){1'b1}}});
		v = (m > lim) ? lim : m;
		return neg ? word_t'(-v[WORD_WIDTH-1:0]) : word_t'(v[WORD_WIDTH-1:0]);
	endfunction
endpackage

[rtl/srfc_mul.sv]
// srfc_mul: shared registered q-format multiplier, one product per call
// depends on srfc_pkg
`timescale 1ns / 1ps
module srfc_mul import srfc_pkg::*; (
	input  logic clk,
	input  word_t a,
	input  word_t b,
	output word_t q,
	output logic [PROD_W-1:0] raw_mag,
	output logic raw_neg
);
	logic [PROD_W-1:0] p;
	logic [PROD_W-1:0] sh;
	assign p = PROD_W'(mag(a)) * PROD_W'(mag(b));
	assign sh = p >> FRAC_BITS;
	always_ff @(posedge clk) begin
		q <= sat_mag(a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1], sh);
		raw_mag <= p;
		raw_neg <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
	end
endmodule

[rtl/srfc_div.sv]
// srfc_div: restoring bit-serial divider, wide magnitude by word magnitude
// depends on srfc_pkg
`timescale 1ns / 1ps
module srfc_div import srfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [PROD_W-1:0] num,
	input  logic [WORD_WIDTH-1:0] den,
	output div_ctl_t ctl,
	output logic [PROD_W-1:0] quo
);
	logic [PROD_W-1:0] n_q;
	logic [WORD_WIDTH:0] r_q;
	logic [WORD_WIDTH-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WORD_WIDTH:0] rs;
	logic ge;
	assign rs = {r_q[WORD_WIDTH-1:0], n_q[PROD_W-1]};
	assign ge = rs >= {1'b0, d_q};
	assign ctl.start = start;
	assign ctl.busy = cnt_q != '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(PROD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			quo <= '0;
		end else if (cnt_q != '0) begin
			n_q <= n_q << 1;
			r_q <= ge ? rs - {1'b0, d_q} : rs;
			quo <= {quo[PROD_W-2:0], ge};
		end
	end
endmodule

[rtl/secant_root_finder_cubic.sv]
// secant root finder on x^3-2x-5: each iteration runs the ten sequencer steps and then waits
// in S_DIV until the divider has produced every quotient bit
// one word at a time, in_stall high while busy; ready again in the cycle after the result is taken
// throughput set by the bit-serial divider, one quotient bit a cycle
// asynchronous active-low reset clears control state and loads register defaults
`timescale 1ns / 1ps
module secant_root_finder_cubic import srfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] first_guess,
	input  logic signed [31:0] second_guess,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] root,
	output logic [7:0] iterations_used,
	output logic [1:0] status,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [30:0] cfg_data
);
	state_t state_q, state_d;
	logic [TOL_W-1:0] tol_q;
	logic [ITER_W-1:0] maxit_q, it_q;
	word_t xp_q, x0_q, f0_q, fp_q, den_q, h;
	word_t ma, mb, mq;
	logic [PROD_W-1:0] mraw;
	logic mneg, nneg_q;
	logic [PROD_W-1:0] quo;
	div_ctl_t dctl;
	logic div_start;

	srfc_mul u_mul (.clk, .a(ma), .b(mb), .q(mq), .raw_mag(mraw), .raw_neg(mneg));
	srfc_div u_div (.clk, .arst_n, .start(div_start), .num(mraw), .den(mag(den_q)),
		.ctl(dctl), .quo(quo));

	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_DONE;
	assign h = sat_mag(nneg_q ^ den_q[WORD_WIDTH-1], quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q <= TOL_W'(66);
			maxit_q <= ITER_W'(20);
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_TOLERANCE) tol_q <= cfg_data;
			if (cfg_we && cfg_index == REG_MAX_ITER) maxit_q <= cfg_data[ITER_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		ma = x0_q;
		mb = x0_q;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHECK;
			S_CHECK: state_d = (it_q == maxit_q) ? S_DONE : S_F0A;
			S_F0A: state_d = S_F0B;
			S_F0B: begin ma = mq; state_d = S_F0C; end
			S_F0C: begin ma = xp_q; mb = xp_q; state_d = S_FPA; end
			S_FPA: begin ma = xp_q; mb = xp_q; state_d = S_FPB; end
			S_FPB: begin ma = mq; mb = xp_q; state_d = S_FPC; end
			S_FPC: state_d = S_DEN;
			S_DEN: begin
				ma = f0_q;
				mb = sat_sub(x0_q, xp_q);
				state_d = (sat_sub(f0_q, fp_q) == '0) ? S_DONE : S_NUM;
			end
			S_NUM: begin div_start = 1'b1; state_d = S_DIV; end
			S_DIV: if (!dctl.busy && !dctl.start) state_d = S_STEP;
			S_STEP: state_d = ({1'b0, mag(h)} < {2'b0, tol_q}) ? S_DONE : S_CHECK;
			S_DONE: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				xp_q <= first_guess;
				x0_q <= second_guess;
				root <= second_guess;
				it_q <= '0;
				status <= ST_LIMIT;
			end
			S_F0C: f0_q <= sat_sub(sat_sub(mq, sat_add(x0_q, x0_q)), FIVE);
			S_FPC: fp_q <= sat_sub(sat_sub(mq, sat_add(xp_q, xp_q)), FIVE);
			S_DEN: begin
				den_q <= sat_sub(f0_q, fp_q);
				if (sat_sub(f0_q, fp_q) == '0) status <= ST_ZERO_DEN;
			end
			S_NUM: nneg_q <= mneg;
			S_STEP: begin
				root <= sat_sub(x0_q, h);
				it_q <= it_q + 1'b1;
				xp_q <= x0_q;
				x0_q <= sat_sub(x0_q, h);
				if ({1'b0, mag(h)} < {2'b0, tol_q}) status <= ST_CONVERGED;
			end
			default: ;
		endcase
	end
	assign iterations_used = it_q;
endmodule

[rtl/srfc_checker.sv]
// srfc_props: port-level checks on the secant root finder
// depends on srfc_pkg; bound to secant_root_finder_cubic
`timescale 1ns / 1ps
module srfc_props import srfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] status,
	input logic [7:0] iterations_used
);
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while word waits");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled word changed");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_CONVERGED || status == ST_LIMIT || status == ST_ZERO_DEN)
		else $error("bad status");
	a_conv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CONVERGED |-> iterations_used != '0)
		else $error("converged without iterating");
endmodule

bind secant_root_finder_cubic srfc_props u_chk (.clk, .arst_n, .in_valid, .in_stall,
	.out_valid, .out_stall, .status, .iterations_used);
